@@ src/lpb_pkg.sv @@
// Shared types, codes and helpers for the layer priority blend block.
// Used by layer_priority_blend; depends on nothing else.

package lpb_pkg;

    localparam int unsigned CHAN_W   = 5;
    localparam int unsigned COLOR_W  = 3 * CHAN_W;
    localparam int unsigned PROD_W   = 9;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned NUM_LAYERS = 4;

    localparam logic [2:0]        BACKDROP_LAYER = 3'd4;
    localparam logic [1:0]        BACKDROP_PRIO  = 2'd3;
    localparam logic [4:0]        WEIGHT_MAX     = 5'd16;
    localparam logic [CHAN_W-1:0] CHAN_MAX       = 5'd31;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [2:0]         layer_t;

    // Register indexes of the configuration space.
    typedef enum logic [2:0] {
        REG_BLEND_CONTROL = 3'd0,
        REG_ALPHA_FIRST   = 3'd1,
        REG_ALPHA_SECOND  = 3'd2,
        REG_BRIGHTNESS    = 3'd3,
        REG_FIRST_LAYER   = 3'd4,
        REG_LAST_LAYER    = 3'd5
    } reg_idx_t;

    // Blend mode field of blend_control.
    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_ALPHA    = 2'd1,
        MODE_BRIGHTEN = 2'd2,
        MODE_DARKEN   = 2'd3
    } blend_mode_t;

    // Operation decided for one pixel once the target enables are known.
    typedef enum logic [1:0] {
        OP_PASS    = 2'd0,
        OP_ALPHA   = 2'd1,
        OP_BRIGHT  = 2'd2,
        OP_DARK    = 2'd3
    } pix_op_t;

    function automatic logic [4:0] clamp_weight(input logic [4:0] w);
        return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
    endfunction

    // Layers 0 to 3 use enable bits 0 to 3; the backdrop uses bit 5.
    function automatic logic [2:0] target_bit(input layer_t layer);
        return (layer >= BACKDROP_LAYER) ? 3'd5 : {1'b0, layer[1:0]};
    endfunction

endpackage

@@ src/layer_priority_blend.sv @@
// Top level of the layer priority blend: pixel pipeline and configuration registers.
// Depends on lpb_pkg.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-------------------------------------
//  pixel in  | pixel_valid / pixel_stall          | layer0..3 color and info, backdrop
//  result    | result_valid / result_stall        | red_out, green_out, blue_out, top_layer
//  config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// One pixel per clock while the result side is not stalled; each pixel passes through the
// stage registers below before its result is valid and can transfer.
// Stage 1 sorts the layers by priority, stage 2 holds the 5x5 weight multipliers,
// stage 3 scales, saturates and registers the output.
// Each stage moves on when the stage after it is empty or moving, so a stalled result
// holds only the stages behind it that are full.
// Reset clears the valid bits and sets the registers to their defaults.

module layer_priority_blend
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [14:0]                   layer0_color,
    input  logic [2:0]                    layer0_info,
    input  logic [14:0]                   layer1_color,
    input  logic [2:0]                    layer1_info,
    input  logic [14:0]                   layer2_color,
    input  logic [2:0]                    layer2_info,
    input  logic [14:0]                   layer3_color,
    input  logic [2:0]                    layer3_info,
    input  logic [14:0]                   backdrop_color,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [7:0]                    red_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    blue_out,
    output logic [2:0]                    top_layer,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpb_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpb_pkg::DATA_W-1:0]    pwdata,
    output logic [lpb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [13:0]          blend_control_reg;
    logic [4:0]           alpha_first_reg;
    logic [4:0]           alpha_second_reg;
    logic [4:0]           brightness_reg;
    logic [1:0]           first_layer_reg;
    logic [1:0]           last_layer_reg;
    logic                 cfg_write;
    lpb_pkg::reg_idx_t    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = lpb_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_control_reg <= '0;
            alpha_first_reg   <= '0;
            alpha_second_reg  <= '0;
            brightness_reg    <= '0;
            first_layer_reg   <= 2'd0;
            last_layer_reg    <= 2'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                lpb_pkg::REG_BLEND_CONTROL: blend_control_reg <= pwdata[13:0];
                lpb_pkg::REG_ALPHA_FIRST:   alpha_first_reg   <= pwdata[4:0];
                lpb_pkg::REG_ALPHA_SECOND:  alpha_second_reg  <= pwdata[4:0];
                lpb_pkg::REG_BRIGHTNESS:    brightness_reg    <= pwdata[4:0];
                lpb_pkg::REG_FIRST_LAYER:   first_layer_reg   <= pwdata[1:0];
                lpb_pkg::REG_LAST_LAYER:    last_layer_reg    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lpb_pkg::REG_BLEND_CONTROL: prdata = {18'd0, blend_control_reg};
            lpb_pkg::REG_ALPHA_FIRST:   prdata = {27'd0, alpha_first_reg};
            lpb_pkg::REG_ALPHA_SECOND:  prdata = {27'd0, alpha_second_reg};
            lpb_pkg::REG_BRIGHTNESS:    prdata = {27'd0, brightness_reg};
            lpb_pkg::REG_FIRST_LAYER:   prdata = {30'd0, first_layer_reg};
            lpb_pkg::REG_LAST_LAYER:    prdata = {30'd0, last_layer_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic adv1;
    logic adv2;
    logic adv3;

    assign adv3        = !out_valid_reg || !result_stall;
    assign adv2        = !s2_valid_reg || adv3;
    assign adv1        = !s1_valid_reg || adv2;
    assign pixel_stall = !adv1;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: priority sort and operation select
    // ------------------------------------------------------------------
    lpb_pkg::color_t   lay_color [lpb_pkg::NUM_LAYERS];
    logic [2:0]        lay_info  [lpb_pkg::NUM_LAYERS];
    logic [1:0]        p1;
    logic [1:0]        p2;
    lpb_pkg::layer_t   l1;
    lpb_pkg::layer_t   l2;
    lpb_pkg::color_t   c1;
    lpb_pkg::color_t   c2;
    logic              first_hit;
    logic              second_hit;
    lpb_pkg::pix_op_t  s1_op_next;

    assign lay_color[0] = layer0_color;
    assign lay_color[1] = layer1_color;
    assign lay_color[2] = layer2_color;
    assign lay_color[3] = layer3_color;
    assign lay_info[0]  = layer0_info;
    assign lay_info[1]  = layer1_info;
    assign lay_info[2]  = layer2_info;
    assign lay_info[3]  = layer3_info;

    // Scan from the highest layer down, so that on equal priority the lower index wins.
    always_comb
    begin
        p1 = lpb_pkg::BACKDROP_PRIO;
        p2 = lpb_pkg::BACKDROP_PRIO;
        l1 = lpb_pkg::BACKDROP_LAYER;
        l2 = lpb_pkg::BACKDROP_LAYER;
        c1 = backdrop_color;
        c2 = backdrop_color;
        for (int i = lpb_pkg::NUM_LAYERS - 1; i >= 0; i--)
        begin
            if ((2'(i) <= last_layer_reg) && (2'(i) >= first_layer_reg) && lay_info[i][2])
            begin
                if (lay_info[i][1:0] <= p1)
                begin
                    p2 = p1;
                    l2 = l1;
                    c2 = c1;
                    p1 = lay_info[i][1:0];
                    l1 = 3'(i);
                    c1 = lay_color[i];
                end
                else if (lay_info[i][1:0] <= p2)
                begin
                    p2 = lay_info[i][1:0];
                    l2 = 3'(i);
                    c2 = lay_color[i];
                end
            end
        end
    end

    assign first_hit  = blend_control_reg[{1'b0, lpb_pkg::target_bit(l1)}];
    assign second_hit = blend_control_reg[{1'b0, lpb_pkg::target_bit(l2)} + 4'd8];

    always_comb
    begin
        s1_op_next = lpb_pkg::OP_PASS;
        if (first_hit)
        begin
            unique case (lpb_pkg::blend_mode_t'(blend_control_reg[7:6]))
                lpb_pkg::MODE_NONE:     s1_op_next = lpb_pkg::OP_PASS;
                lpb_pkg::MODE_ALPHA:    s1_op_next = second_hit ? lpb_pkg::OP_ALPHA
                                                                : lpb_pkg::OP_PASS;
                lpb_pkg::MODE_BRIGHTEN: s1_op_next = lpb_pkg::OP_BRIGHT;
                lpb_pkg::MODE_DARKEN:   s1_op_next = lpb_pkg::OP_DARK;
                default:                s1_op_next = lpb_pkg::OP_PASS;
            endcase
        end
    end

    lpb_pkg::color_t   s1_c1_reg;
    lpb_pkg::color_t   s1_c2_reg;
    lpb_pkg::layer_t   s1_layer_reg;
    lpb_pkg::pix_op_t  s1_op_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_c1_reg    <= c1;
            s1_c2_reg    <= c2;
            s1_layer_reg <= l1;
            s1_op_reg    <= s1_op_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weight products, one pair of small multipliers per channel
    // ------------------------------------------------------------------
    logic [4:0]        eva;
    logic [4:0]        evb;
    logic [4:0]        evy;
    lpb_pkg::prod_t    prod_a_next [3];
    lpb_pkg::prod_t    prod_b_next [3];

    assign eva = lpb_pkg::clamp_weight(alpha_first_reg);
    assign evb = lpb_pkg::clamp_weight(alpha_second_reg);
    assign evy = lpb_pkg::clamp_weight(brightness_reg);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod_a_next[ch] = '0;
            prod_b_next[ch] = '0;
            case (s1_op_reg)
                lpb_pkg::OP_ALPHA:
                begin
                    prod_a_next[ch] = 9'(s1_c1_reg[ch*5 +: 5]) * 9'(eva);
                    prod_b_next[ch] = 9'(s1_c2_reg[ch*5 +: 5]) * 9'(evb);
                end
                lpb_pkg::OP_BRIGHT:
                begin
                    prod_a_next[ch] = 9'(lpb_pkg::CHAN_MAX - s1_c1_reg[ch*5 +: 5]) * 9'(evy);
                end
                lpb_pkg::OP_DARK:
                begin
                    prod_a_next[ch] = 9'(s1_c1_reg[ch*5 +: 5]) * 9'(evy);
                end
                default: ;
            endcase
        end
    end

    lpb_pkg::prod_t    s2_prod_a_reg [3];
    lpb_pkg::prod_t    s2_prod_b_reg [3];
    lpb_pkg::color_t   s2_c1_reg;
    lpb_pkg::layer_t   s2_layer_reg;
    lpb_pkg::pix_op_t  s2_op_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_prod_a_reg <= prod_a_next;
            s2_prod_b_reg <= prod_b_next;
            s2_c1_reg     <= s1_c1_reg;
            s2_layer_reg  <= s1_layer_reg;
            s2_op_reg     <= s1_op_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale, saturate, output register
    // ------------------------------------------------------------------
    lpb_pkg::chan_t    chan_next [3];
    logic [5:0]        alpha_sum [3];
    lpb_pkg::chan_t    src_chan  [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            src_chan[ch]  = s2_c1_reg[ch*5 +: 5];
            alpha_sum[ch] = {1'b0, s2_prod_a_reg[ch][8:4]} + {1'b0, s2_prod_b_reg[ch][8:4]};
            case (s2_op_reg)
                lpb_pkg::OP_ALPHA:
                    chan_next[ch] = (alpha_sum[ch] > 6'(lpb_pkg::CHAN_MAX))
                                  ? lpb_pkg::CHAN_MAX : alpha_sum[ch][4:0];
                lpb_pkg::OP_BRIGHT:
                    chan_next[ch] = src_chan[ch] + s2_prod_a_reg[ch][8:4];
                lpb_pkg::OP_DARK:
                    chan_next[ch] = src_chan[ch] - s2_prod_a_reg[ch][8:4];
                default:
                    chan_next[ch] = src_chan[ch];
            endcase
        end
    end

    lpb_pkg::chan_t    red_reg;
    lpb_pkg::chan_t    green_reg;
    lpb_pkg::chan_t    blue_reg;
    lpb_pkg::layer_t   top_layer_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            red_reg       <= chan_next[0];
            green_reg     <= chan_next[1];
            blue_reg      <= chan_next[2];
            top_layer_reg <= s2_layer_reg;
        end
    end

    assign red_out   = {red_reg, 3'b000};
    assign green_out = {green_reg, 3'b000};
    assign blue_out  = {blue_reg, 3'b000};
    assign top_layer = top_layer_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The input is held back only when every stage is full and the result is stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled while the pipeline has room");

    // A pixel transfer always lands in the first stage.
    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> s1_valid_reg)
        else $error("accepted pixel lost at stage one");

    // A full middle stage that cannot move keeps its item.
    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !adv3) |=> (s2_valid_reg && $stable(s2_layer_reg)))
        else $error("stage two item dropped or changed under stall");

    // The winning layer is a real layer or the backdrop.
    a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (top_layer <= lpb_pkg::BACKDROP_LAYER))
        else $error("winning layer out of range");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for layer_priority_blend: directed pixels and register settings,
// then random pixel streams under random idling and a long result hold-off.
// Depends on lpb_pkg and layer_priority_blend.

module tb_top;

    localparam int unsigned REG_STRIDE       = 4;
    localparam int unsigned FIRST_UNUSED_REG = 6;
    localparam int unsigned IDLE_PCT         = 8;
    localparam int unsigned RANDOM_PHASES    = 7;
    localparam int unsigned RANDOM_BATCH     = 220;
    localparam int unsigned QUIET_BATCH      = 250;
    localparam int unsigned PRESSURE_BATCH   = 160;
    localparam int unsigned HOLD_CYCLES      = 120;
    localparam int unsigned TAIL_CYCLES      = 10;
    localparam int unsigned TIMEOUT_NS       = 5_000_000;

    typedef struct packed {
        logic [lpb_pkg::NUM_LAYERS-1:0][lpb_pkg::COLOR_W-1:0] color;
        logic [lpb_pkg::NUM_LAYERS-1:0][2:0]                  info;
        lpb_pkg::color_t                                      backdrop;
    } pixel_t;

    typedef struct packed {
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        lpb_pkg::layer_t top;
    } result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        pixel_valid;
    wire                         pixel_stall;
    pixel_t                      pix_in;
    wire  [14:0]                 layer0_color;
    wire  [2:0]                  layer0_info;
    wire  [14:0]                 layer1_color;
    wire  [2:0]                  layer1_info;
    wire  [14:0]                 layer2_color;
    wire  [2:0]                  layer2_info;
    wire  [14:0]                 layer3_color;
    wire  [2:0]                  layer3_info;
    wire  [14:0]                 backdrop_color;
    wire                         result_valid;
    logic                        result_stall;
    wire  [7:0]                  red_out;
    wire  [7:0]                  green_out;
    wire  [7:0]                  blue_out;
    wire  [2:0]                  top_layer;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lpb_pkg::ADDR_W-1:0]  paddr;
    logic [lpb_pkg::DATA_W-1:0]  pwdata;
    wire  [lpb_pkg::DATA_W-1:0]  prdata;
    wire                         pready;

    // Register copies used by the predictor.
    logic [13:0]        cfg_ctrl;
    logic [4:0]         cfg_eva;
    logic [4:0]         cfg_evb;
    logic [4:0]         cfg_evy;
    logic [1:0]         cfg_first;
    logic [1:0]         cfg_last;

    result_t            pending_rgb[$];
    int unsigned        n_errors;
    int unsigned        n_pixels;
    int unsigned        n_writes;
    logic               quiet_run;
    int unsigned        hold_request;

    assign layer0_color   = pix_in.color[0];
    assign layer0_info    = pix_in.info[0];
    assign layer1_color   = pix_in.color[1];
    assign layer1_info    = pix_in.info[1];
    assign layer2_color   = pix_in.color[2];
    assign layer2_info    = pix_in.info[2];
    assign layer3_color   = pix_in.color[3];
    assign layer3_info    = pix_in.info[3];
    assign backdrop_color = pix_in.backdrop;

    layer_priority_blend u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .layer0_color   (layer0_color),
        .layer0_info    (layer0_info),
        .layer1_color   (layer1_color),
        .layer1_info    (layer1_info),
        .layer2_color   (layer2_color),
        .layer2_info    (layer2_info),
        .layer3_color   (layer3_color),
        .layer3_info    (layer3_info),
        .backdrop_color (backdrop_color),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .top_layer      (top_layer),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int weight_of(input logic [4:0] w);
        return (w > lpb_pkg::WEIGHT_MAX) ? int'(lpb_pkg::WEIGHT_MAX) : int'(w);
    endfunction

    // The backdrop takes the enable bit just above the unused bit 4.
    function automatic int enable_bit(input lpb_pkg::layer_t layer);
        return (layer == lpb_pkg::BACKDROP_LAYER) ? 5 : int'(layer);
    endfunction

    function automatic lpb_pkg::color_t mix_weighted(input lpb_pkg::color_t upper,
                                                     input lpb_pkg::color_t lower);
        int              eva;
        int              evb;
        int              a;
        int              b;
        int              v;
        int              ch;
        lpb_pkg::color_t res;
        eva = weight_of(cfg_eva);
        evb = weight_of(cfg_evb);
        res = '0;
        for (ch = 0; ch < 3; ch++)
        begin
            a = int'(upper[ch*lpb_pkg::CHAN_W +: lpb_pkg::CHAN_W]);
            b = int'(lower[ch*lpb_pkg::CHAN_W +: lpb_pkg::CHAN_W]);
            v = ((a * eva) >> 4) + ((b * evb) >> 4);
            if (v > int'(lpb_pkg::CHAN_MAX))
                v = int'(lpb_pkg::CHAN_MAX);
            res[ch*lpb_pkg::CHAN_W +: lpb_pkg::CHAN_W] = v[lpb_pkg::CHAN_W-1:0];
        end
        return res;
    endfunction

    function automatic lpb_pkg::color_t mix_brightness(input logic up,
                                                       input lpb_pkg::color_t c);
        int              evy;
        int              v;
        int              ch;
        lpb_pkg::color_t res;
        evy = weight_of(cfg_evy);
        res = '0;
        for (ch = 0; ch < 3; ch++)
        begin
            v = int'(c[ch*lpb_pkg::CHAN_W +: lpb_pkg::CHAN_W]);
            if (up)
                v = v + (((int'(lpb_pkg::CHAN_MAX) - v) * evy) >> 4);
            else
                v = v - ((v * evy) >> 4);
            res[ch*lpb_pkg::CHAN_W +: lpb_pkg::CHAN_W] = v[lpb_pkg::CHAN_W-1:0];
        end
        return res;
    endfunction

    function automatic result_t predict_blend(input pixel_t px);
        logic [1:0]           p1;
        logic [1:0]           p2;
        logic [1:0]           pr;
        lpb_pkg::layer_t      l1;
        lpb_pkg::layer_t      l2;
        lpb_pkg::color_t      c1;
        lpb_pkg::color_t      c2;
        lpb_pkg::color_t      col;
        lpb_pkg::blend_mode_t mode;
        result_t              r;
        int                   k;
        p1 = lpb_pkg::BACKDROP_PRIO;
        l1 = lpb_pkg::BACKDROP_LAYER;
        c1 = px.backdrop;
        p2 = lpb_pkg::BACKDROP_PRIO;
        l2 = lpb_pkg::BACKDROP_LAYER;
        c2 = px.backdrop;
        // Scanning downwards with <= lets the lower index take a tied priority.
        for (k = lpb_pkg::NUM_LAYERS - 1; k >= 0; k--)
        begin
            if (k >= int'(cfg_first) && k <= int'(cfg_last) && px.info[k][2])
            begin
                pr = px.info[k][1:0];
                if (pr <= p1)
                begin
                    p2 = p1;
                    l2 = l1;
                    c2 = c1;
                    p1 = pr;
                    l1 = lpb_pkg::layer_t'(k);
                    c1 = px.color[k];
                end
                else if (pr <= p2)
                begin
                    p2 = pr;
                    l2 = lpb_pkg::layer_t'(k);
                    c2 = px.color[k];
                end
            end
        end
        mode = lpb_pkg::blend_mode_t'(cfg_ctrl[7:6]);
        col = c1;
        if (mode != lpb_pkg::MODE_NONE && cfg_ctrl[enable_bit(l1)])
        begin
            if (mode == lpb_pkg::MODE_ALPHA)
            begin
                if (cfg_ctrl[8 + enable_bit(l2)])
                    col = mix_weighted(c1, c2);
            end
            else
                col = mix_brightness(mode == lpb_pkg::MODE_BRIGHTEN, c1);
        end
        r.red   = {col[4:0], 3'b000};
        r.green = {col[9:5], 3'b000};
        r.blue  = {col[14:10], 3'b000};
        r.top   = l1;
        return r;
    endfunction

    function automatic pixel_t make_pixel(input logic [4*lpb_pkg::COLOR_W-1:0] colors,
                                          input logic [11:0] infos,
                                          input lpb_pkg::color_t bd);
        pixel_t px;
        px.color    = colors;
        px.info     = infos;
        px.backdrop = bd;
        return px;
    endfunction

    function automatic logic [31:0] ctrl_word(input logic [5:0] first_mask,
                                              input lpb_pkg::blend_mode_t mode,
                                              input logic [5:0] second_mask);
        return {18'd0, second_mask, mode, first_mask};
    endfunction

    function automatic lpb_pkg::color_t rand_color();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return lpb_pkg::color_t'($urandom());
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     k;
        for (k = 0; k < lpb_pkg::NUM_LAYERS; k++)
        begin
            px.color[k] = rand_color();
            px.info[k]  = {($urandom_range(0, 3) != 0), 2'($urandom_range(0, 3))};
        end
        px.backdrop = rand_color();
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px);
        if (!quiet_run)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                @(negedge clk);
                pixel_valid <= 1'b0;
            end
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pix_in      <= px;
        do
            @(posedge clk);
        while (pixel_stall !== 1'b0);
        pending_rgb.insert(pending_rgb.size(), predict_blend(px));
        n_pixels++;
    endtask

    task automatic flush_pixels();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input lpb_pkg::reg_idx_t idx, input logic [31:0] data);
        flush_pixels();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lpb_pkg::ADDR_W'(idx * REG_STRIDE);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            lpb_pkg::REG_BLEND_CONTROL: cfg_ctrl  = data[13:0];
            lpb_pkg::REG_ALPHA_FIRST:   cfg_eva   = data[4:0];
            lpb_pkg::REG_ALPHA_SECOND:  cfg_evb   = data[4:0];
            lpb_pkg::REG_BRIGHTNESS:    cfg_evy   = data[4:0];
            lpb_pkg::REG_FIRST_LAYER:   cfg_first = data[1:0];
            lpb_pkg::REG_LAST_LAYER:    cfg_last  = data[1:0];
            default:                    ;
        endcase
        n_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_random_settings(input lpb_pkg::blend_mode_t mode);
        logic [31:0] ctrl;
        int unsigned lo;
        int unsigned hi;
        ctrl       = $urandom();
        ctrl[7:6]  = mode;
        lo         = $urandom_range(0, 3);
        hi         = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(lo, 3);
        write_reg(lpb_pkg::REG_BLEND_CONTROL, ctrl);
        write_reg(lpb_pkg::REG_ALPHA_FIRST, $urandom());
        write_reg(lpb_pkg::REG_ALPHA_SECOND, $urandom());
        write_reg(lpb_pkg::REG_BRIGHTNESS, $urandom());
        write_reg(lpb_pkg::REG_FIRST_LAYER, ($urandom() & 32'hFFFF_FFFC) | lo);
        write_reg(lpb_pkg::REG_LAST_LAYER, ($urandom() & 32'hFFFF_FFFC) | hi);
    endtask

    task automatic test_default_settings();
        send_pixel(make_pixel({15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
                              {3'd3, 3'd2, 3'd1, 3'd0}, 15'h0000));
        send_pixel(make_pixel({15'h001F, 15'h03E0, 15'h7C00, 15'h7FFF},
                              {3'd4, 3'd4, 3'd4, 3'd4}, 15'h7FFF));
        send_pixel(make_pixel({15'h1234, 15'h0ABC, 15'h2DEF, 15'h3456},
                              {3'd4, 3'd0, 3'd5, 3'd6}, 15'h5555));
        // Lowest priority everywhere: the layers still beat the backdrop on a tie.
        send_pixel(make_pixel({15'h0001, 15'h0020, 15'h0400, 15'h7BDE},
                              {3'd7, 3'd7, 3'd7, 3'd7}, 15'h2108));
    endtask

    task automatic test_empty_range();
        write_reg(lpb_pkg::REG_FIRST_LAYER, 32'hFFFF_FFF3);
        write_reg(lpb_pkg::REG_LAST_LAYER, 32'hFFFF_FFFC);
        send_pixel(make_pixel({15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
                              {3'd4, 3'd4, 3'd4, 3'd4}, 15'h1111));
        write_reg(lpb_pkg::REG_FIRST_LAYER, 32'd2);
        write_reg(lpb_pkg::REG_LAST_LAYER, 32'd1);
        send_pixel(make_pixel({15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
                              {3'd4, 3'd4, 3'd4, 3'd4}, 15'h6666));
        write_reg(lpb_pkg::REG_FIRST_LAYER, 32'd1);
        write_reg(lpb_pkg::REG_LAST_LAYER, 32'd2);
        send_pixel(make_pixel({15'h7C00, 15'h03E0, 15'h001F, 15'h7FFF},
                              {3'd4, 3'd5, 3'd4, 3'd4}, 15'h0000));
        write_reg(lpb_pkg::REG_FIRST_LAYER, 32'd0);
        write_reg(lpb_pkg::REG_LAST_LAYER, 32'd3);
    endtask

    task automatic test_alpha_blend();
        write_reg(lpb_pkg::REG_BLEND_CONTROL,
                  ctrl_word(6'h3F, lpb_pkg::MODE_ALPHA, 6'h3F) | 32'hFFFF_C000);
        write_reg(lpb_pkg::REG_ALPHA_FIRST, 32'hFFFF_FFFF);
        write_reg(lpb_pkg::REG_ALPHA_SECOND, 32'd17);
        // Both weights clamp to 16, so full-scale colours saturate every channel.
        send_pixel(make_pixel({15'h0000, 15'h0000, 15'h7FFF, 15'h7FFF},
                              {3'd0, 3'd0, 3'd5, 3'd4}, 15'h0000));
        send_pixel(make_pixel({15'h0000, 15'h5AD6, 15'h0000, 15'h0000},
                              {3'd0, 3'd6, 3'd0, 3'd0}, 15'h294A));
        send_pixel(make_pixel({15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
                              12'h000, 15'h4210));
        write_reg(lpb_pkg::REG_ALPHA_FIRST, 32'd10);
        write_reg(lpb_pkg::REG_ALPHA_SECOND, 32'd6);
        write_reg(lpb_pkg::REG_BLEND_CONTROL, ctrl_word(6'h3F, lpb_pkg::MODE_ALPHA, 6'h1F));
        send_pixel(make_pixel({15'h0000, 15'h0000, 15'h6B5A, 15'h0000},
                              {3'd0, 3'd0, 3'd5, 3'd0}, 15'h7FFF));
        send_pixel(make_pixel({15'h1F3E, 15'h0000, 15'h6B5A, 15'h0000},
                              {3'd6, 3'd0, 3'd4, 3'd0}, 15'h7FFF));
        write_reg(lpb_pkg::REG_BLEND_CONTROL, ctrl_word(6'h3E, lpb_pkg::MODE_ALPHA, 6'h3F));
        send_pixel(make_pixel({15'h0000, 15'h0000, 15'h7FFF, 15'h3DEF},
                              {3'd0, 3'd0, 3'd5, 3'd4}, 15'h0000));
    endtask

    task automatic test_brightness();
        write_reg(lpb_pkg::REG_BLEND_CONTROL,
                  ctrl_word(6'h3F, lpb_pkg::MODE_BRIGHTEN, 6'h00));
        write_reg(lpb_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFF);
        send_pixel(make_pixel({15'h7FFF, 15'h0000, 15'h7FFF, 15'h7FFF},
                              {3'd0, 3'd4, 3'd0, 3'd0}, 15'h3333));
        send_pixel(make_pixel({15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
                              12'h000, 15'h1CE7));
        write_reg(lpb_pkg::REG_BRIGHTNESS, 32'd8);
        send_pixel(make_pixel({15'h0000, 15'h0000, 15'h0000, 15'h4631},
                              {3'd0, 3'd0, 3'd0, 3'd7}, 15'h0000));
        write_reg(lpb_pkg::REG_BLEND_CONTROL,
                  ctrl_word(6'h1F, lpb_pkg::MODE_DARKEN, 6'h00));
        write_reg(lpb_pkg::REG_BRIGHTNESS, 32'd31);
        send_pixel(make_pixel({15'h7FFF, 15'h0000, 15'h0000, 15'h0000},
                              {3'd5, 3'd0, 3'd0, 3'd0}, 15'h0000));
        // Backdrop wins but its first-target bit is clear, so it passes unchanged.
        write_reg(lpb_pkg::REG_BRIGHTNESS, 32'd12);
        send_pixel(make_pixel({15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
                              {3'd3, 3'd3, 3'd3, 3'd3}, 15'h7FFF));
    endtask

    task automatic test_unused_registers();
        write_reg(lpb_pkg::reg_idx_t'(FIRST_UNUSED_REG), 32'hFFFF_FFFF);
        write_reg(lpb_pkg::reg_idx_t'(FIRST_UNUSED_REG + 1), 32'h0000_0000);
        send_pixel(make_pixel({15'h0000, 15'h0000, 15'h7FFF, 15'h0000},
                              {3'd0, 3'd0, 3'd6, 3'd0}, 15'h0000));
    endtask

    task automatic test_random_settings();
        int unsigned ph;
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(lpb_pkg::REG_BLEND_CONTROL, 32'hFFFF_FFFF);
                    write_reg(lpb_pkg::REG_ALPHA_FIRST, 32'hFFFF_FFFF);
                    write_reg(lpb_pkg::REG_ALPHA_SECOND, 32'hFFFF_FFFF);
                    write_reg(lpb_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFF);
                    write_reg(lpb_pkg::REG_FIRST_LAYER, 32'hFFFF_FFFC);
                    write_reg(lpb_pkg::REG_LAST_LAYER, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_reg(lpb_pkg::REG_BLEND_CONTROL,
                              ctrl_word(6'h3F, lpb_pkg::MODE_ALPHA, 6'h3F));
                    write_reg(lpb_pkg::REG_ALPHA_FIRST, 32'd0);
                    write_reg(lpb_pkg::REG_ALPHA_SECOND, 32'd0);
                    write_reg(lpb_pkg::REG_BRIGHTNESS, 32'd0);
                    write_reg(lpb_pkg::REG_FIRST_LAYER, 32'd0);
                    write_reg(lpb_pkg::REG_LAST_LAYER, 32'd0);
                end
                default: set_random_settings(lpb_pkg::blend_mode_t'((ph + 3) % 4));
            endcase
            repeat (RANDOM_BATCH)
                send_pixel(rand_pixel());
        end
    endtask

    task automatic test_quiet_stretch();
        set_random_settings(lpb_pkg::MODE_ALPHA);
        quiet_run = 1'b1;
        repeat (QUIET_BATCH)
            send_pixel(rand_pixel());
        flush_pixels();
        quiet_run = 1'b0;
    endtask

    task automatic test_backpressure();
        set_random_settings(lpb_pkg::MODE_ALPHA);
        send_pixel(rand_pixel());
        hold_request = HOLD_CYCLES;
        repeat (PRESSURE_BATCH - 1)
            send_pixel(rand_pixel());
    endtask

    // Result side: random stalls, plus one long hold-off counted here.
    initial
    begin
        int unsigned hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet_run && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid === 1'b1 && result_stall == 1'b0)
            begin
                if (pending_rgb.size() == 0)
                begin
                    $error("result transfer with no pixel outstanding");
                    n_errors++;
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    if (red_out !== want.red)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red, red_out);
                        n_errors++;
                    end
                    if (green_out !== want.green)
                    begin
                        $error("green_out: expected %0d, got %0d", want.green, green_out);
                        n_errors++;
                    end
                    if (blue_out !== want.blue)
                    begin
                        $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
                        n_errors++;
                    end
                    if (top_layer !== want.top)
                    begin
                        $error("top_layer: expected %0d, got %0d", want.top, top_layer);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("layer_priority_blend test failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pix_in       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet_run    = 1'b0;
        hold_request = 0;
        n_errors     = 0;
        n_pixels     = 0;
        n_writes     = 0;
        cfg_ctrl     = '0;
        cfg_eva      = '0;
        cfg_evb      = '0;
        cfg_evy      = '0;
        cfg_first    = 2'd0;
        cfg_last     = 2'd3;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_settings();
        test_empty_range();
        test_alpha_blend();
        test_brightness();
        test_unused_registers();
        test_random_settings();
        test_quiet_stretch();
        test_backpressure();

        flush_pixels();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_rgb.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_rgb.size());
            n_errors++;
        end
        $display("Run covered %0d pixel transfers and %0d register writes over all blend modes,",
                 n_pixels, n_writes);
        $display("with empty and partial layer ranges, clamped weights and a long result hold-off.");
        if (n_errors == 0)
            $display("layer_priority_blend test passed");
        else
            $display("layer_priority_blend test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/lpb_pkg.sv
src/layer_priority_blend.sv
dv/tb_top.sv
